// File: rtl/button_transition_event_queue_core_assert.svh
// Assertion macros shared by the button event queue RTL.
`ifndef BUTTON_TRANSITION_EVENT_QUEUE_CORE_ASSERT_SVH
`define BUTTON_TRANSITION_EVENT_QUEUE_CORE_ASSERT_SVH

// Clocked property check, disabled while in reset.
`define BTNQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Plain invariant that must hold at every edge out of reset.
`define BTNQ_ASSERT_HOLDS(label, expr, msg) \
  `BTNQ_ASSERT(label, expr, msg)

`endif

// File: rtl/btnq_pkg.sv
// Shared types and constants for the button event queue.
package btnq_pkg;

  localparam int NUM_REGS     = 5;
  localparam int LEVEL_BITS   = 5;
  localparam int CODE_W       = 8;
  localparam int REG_IDX_W    = 3;
  localparam int MAX_BUTTONS  = 16;
  localparam int IDX_W        = 4;

  localparam int BUTTON_COUNT_DEF = 5;
  localparam int COUNT_BITS_DEF   = 8;

  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_POLL   = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_CODE_A    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CODE_B    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CODE_EXIT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CODE_UP   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CODE_DOWN = 3'd4;

  typedef enum logic [1:0] {
    CHANGE_NONE    = 2'd0,
    CHANGE_PRESS   = 2'd1,
    CHANGE_RELEASE = 2'd2
  } change_t;

  typedef struct packed {
    logic                  poll;
    logic [LEVEL_BITS-1:0] levels;
  } op_t;

  typedef struct packed {
    logic             found;
    logic             is_press;
    logic [IDX_W-1:0] index;
  } pick_t;

endpackage

// File: rtl/btnq_if.sv
// Valid/ready channel interfaces for the button event queue.
interface btnq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [btnq_pkg::LEVEL_BITS-1:0] levels;

  modport source (output valid, action, levels, input ready);
  modport sink   (input valid, action, levels, output ready);
endinterface

interface btnq_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                change;
  logic [btnq_pkg::CODE_W-1:0] button_code;
  logic                      pressed;

  modport source (output valid, change, button_code, pressed, input ready);
  modport sink   (input valid, change, button_code, pressed, output ready);
endinterface

// File: rtl/btnq_cfg.sv
// Button code registers with a plain write port.
module btnq_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               write_enable,
  input  logic [btnq_pkg::REG_IDX_W-1:0]     write_index,
  input  logic [btnq_pkg::CODE_W-1:0]        write_data,
  output logic [btnq_pkg::CODE_W-1:0]        codes [btnq_pkg::NUM_REGS]
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < btnq_pkg::NUM_REGS; k++) begin
        codes[k] <= btnq_pkg::CODE_W'(k);
      end
    end else if (write_enable) begin
      // indexes past the last register fall through
      for (int k = 0; k < btnq_pkg::NUM_REGS; k++) begin
        if (write_index == btnq_pkg::REG_IDX_W'(k)) begin
          codes[k] <= write_data;
        end
      end
    end
  end

endmodule

// File: rtl/btnq_state.sv
// Per-button transition counters and the priority pick for polls.
module btnq_state #(
  parameter int BUTTON_COUNT = btnq_pkg::BUTTON_COUNT_DEF,
  parameter int COUNT_BITS   = btnq_pkg::COUNT_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  btnq_pkg::op_t   op,
  output btnq_pkg::pick_t pick
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic                  level_now      [BUTTON_COUNT];
  logic                  level_reported [BUTTON_COUNT];
  logic [COUNT_BITS-1:0] release_pending[BUTTON_COUNT];
  logic [COUNT_BITS-1:0] press_pending  [BUTTON_COUNT];

  logic [BUTTON_COUNT-1:0]          grant;
  logic [btnq_pkg::MAX_BUTTONS-1:0] lv_ext;

  assign lv_ext = btnq_pkg::MAX_BUTTONS'(op.levels);

  // first button with a transition that may follow its last report
  always_comb begin
    logic seen;
    logic cand;
    seen          = 1'b0;
    pick.found    = 1'b0;
    pick.is_press = 1'b0;
    pick.index    = '0;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      cand = level_reported[i] ? (release_pending[i] != '0)
                               : (press_pending[i] != '0);
      grant[i] = cand && !seen;
      seen     = seen | cand;
      if (grant[i]) begin
        pick.found    = 1'b1;
        pick.is_press = !level_reported[i];
        pick.index    = btnq_pkg::IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        level_now[i]       <= 1'b0;
        level_reported[i]  <= 1'b0;
        release_pending[i] <= '0;
        press_pending[i]   <= '0;
      end
    end else if (fire) begin
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        if (op.poll == btnq_pkg::ACT_POLL) begin
          if (grant[i]) begin
            level_reported[i] <= !level_reported[i];
            if (level_reported[i]) begin
              release_pending[i] <= release_pending[i] - 1'b1;
            end else begin
              press_pending[i] <= press_pending[i] - 1'b1;
            end
          end
        end else if (lv_ext[i] != level_now[i]) begin
          level_now[i] <= lv_ext[i];
          if (level_now[i]) begin
            if (release_pending[i] != CNT_MAX) begin
              release_pending[i] <= release_pending[i] + 1'b1;
            end
          end else begin
            if (press_pending[i] != CNT_MAX) begin
              press_pending[i] <= press_pending[i] + 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

// File: rtl/button_transition_event_queue_core.sv
// Button transition event queue: input register, counter state, result register.
//
// Takes one word per cycle on in_ch. An update word records button levels
// and yields nothing; a poll word yields one result word on out_ch by way of
// the input register and the result register. The counters and priority
// pick sit between the input register and the result register, so a new
// word is taken every cycle; in_ch.ready drops only while a poll sits in
// the input register and the result register holds a word that out_ch is not taking.
`include "button_transition_event_queue_core_assert.svh"

module button_transition_event_queue_core #(
  parameter int BUTTON_COUNT = btnq_pkg::BUTTON_COUNT_DEF,
  parameter int COUNT_BITS   = btnq_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           write_enable,
  input  logic [btnq_pkg::REG_IDX_W-1:0] write_index,
  input  logic [btnq_pkg::CODE_W-1:0]    write_data,
  btnq_in_if.sink                        in_ch,
  btnq_out_if.source                     out_ch
);

  logic [btnq_pkg::CODE_W-1:0] codes [btnq_pkg::NUM_REGS];

  logic                        s1_valid;
  btnq_pkg::op_t               s1_op;
  logic                        advance;
  btnq_pkg::pick_t             pick;
  logic [btnq_pkg::CODE_W-1:0] pick_code;

  logic                        res_valid;
  btnq_pkg::change_t           res_change;
  logic [btnq_pkg::CODE_W-1:0] res_code;
  logic                        res_pressed;

  btnq_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .codes        (codes)
  );

  btnq_state #(
    .BUTTON_COUNT (BUTTON_COUNT),
    .COUNT_BITS   (COUNT_BITS)
  ) u_state (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .op   (s1_op),
    .pick (pick)
  );

  assign advance     = s1_valid && (s1_op.poll == btnq_pkg::ACT_UPDATE
                                    || !res_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;

  // buttons without a code register report 0
  always_comb begin
    pick_code = '0;
    for (int k = 0; k < btnq_pkg::NUM_REGS; k++) begin
      if (pick.found && pick.index == btnq_pkg::IDX_W'(k)) begin
        pick_code = codes[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid <= in_ch.valid;
      end
      if (advance && s1_op.poll == btnq_pkg::ACT_POLL) begin
        res_valid <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op.poll   <= in_ch.action;
      s1_op.levels <= in_ch.levels;
    end
    if (advance && s1_op.poll == btnq_pkg::ACT_POLL) begin
      if (!pick.found) begin
        res_change <= btnq_pkg::CHANGE_NONE;
      end else if (pick.is_press) begin
        res_change <= btnq_pkg::CHANGE_PRESS;
      end else begin
        res_change <= btnq_pkg::CHANGE_RELEASE;
      end
      res_code    <= pick_code;
      res_pressed <= pick.found && pick.is_press;
    end
  end

  assign out_ch.valid       = res_valid;
  assign out_ch.change      = res_change;
  assign out_ch.button_code = res_code;
  assign out_ch.pressed     = res_pressed;

  `BTNQ_ASSERT(a_poll_gives_word, s1_valid && s1_op.poll == btnq_pkg::ACT_POLL && advance |=> res_valid, "poll word lost")
  `BTNQ_ASSERT(a_word_from_poll, $rose(res_valid) |-> $past(s1_valid && s1_op.poll == btnq_pkg::ACT_POLL), "result word without a poll")
  `BTNQ_ASSERT_HOLDS(a_none_is_blank, res_valid && res_change == btnq_pkg::CHANGE_NONE |-> res_code == '0 && !res_pressed, "empty result carries data")
  `BTNQ_ASSERT_HOLDS(a_pressed_flag, res_valid |-> res_pressed == (res_change == btnq_pkg::CHANGE_PRESS), "pressed flag disagrees with change")

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the button transition event queue core.
`timescale 1ns / 1ps

module tb_top;
  import btnq_pkg::*;

  localparam int BTN_N         = BUTTON_COUNT_DEF;
  localparam int CNT_W         = COUNT_BITS_DEF;
  localparam int STALL_LIMIT   = 3000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_SHOWN     = 10;

  localparam logic [CNT_W-1:0] CNT_FULL = '1;
  localparam logic [REG_IDX_W-1:0] REG_ORDER [NUM_REGS] = '{
    REG_CODE_A, REG_CODE_B, REG_CODE_EXIT, REG_CODE_UP, REG_CODE_DOWN
  };

  typedef struct packed {
    change_t             change;
    logic [CODE_W-1:0]   code;
    logic                pressed;
  } btn_event_t;

  typedef logic [CODE_W-1:0] code_set_t [NUM_REGS];

  logic                 clk;
  logic                 rst;
  logic                 write_enable;
  logic [REG_IDX_W-1:0] write_index;
  logic [CODE_W-1:0]    write_data;

  btnq_in_if  in_ch ();
  btnq_out_if out_ch ();

  button_transition_event_queue_core #(
    .BUTTON_COUNT (BTN_N),
    .COUNT_BITS   (CNT_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch)
  );

  // predicted button state
  logic [BTN_N-1:0]  btn_level;
  logic [BTN_N-1:0]  btn_shown;
  logic [CNT_W-1:0]  press_cnt [BTN_N];
  logic [CNT_W-1:0]  release_cnt [BTN_N];
  logic [CODE_W-1:0] code_reg [NUM_REGS];

  btn_event_t        pending_events [$];
  int                err_count;
  int                stall_cycles;

  // stimulus control
  int                gap_max;
  int                burst_left;
  logic [LEVEL_BITS-1:0] sent_levels;
  bit                hold_go;
  int                hold_len;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void record_levels(input logic [LEVEL_BITS-1:0] lv);
    int i;
    for (i = 0; i < BTN_N; i++) begin
      if (btn_level[i] != lv[i]) begin
        if (btn_level[i]) begin
          if (release_cnt[i] != CNT_FULL) release_cnt[i]++;
        end else begin
          if (press_cnt[i] != CNT_FULL) press_cnt[i]++;
        end
        btn_level[i] = lv[i];
      end
    end
  endfunction

  function automatic btn_event_t take_next_event();
    btn_event_t ev;
    int i;
    ev = '{change: CHANGE_NONE, code: '0, pressed: 1'b0};
    for (i = 0; i < BTN_N; i++) begin
      if (btn_shown[i] && release_cnt[i] != '0) begin
        release_cnt[i]--;
        btn_shown[i] = 1'b0;
        ev.change    = CHANGE_RELEASE;
        ev.code      = code_reg[i];
        return ev;
      end
      if (!btn_shown[i] && press_cnt[i] != '0) begin
        press_cnt[i]--;
        btn_shown[i] = 1'b1;
        ev.change    = CHANGE_PRESS;
        ev.code      = code_reg[i];
        ev.pressed   = 1'b1;
        return ev;
      end
    end
    return ev;
  endfunction

  function automatic void log_error(input string msg);
    err_count++;
    if (err_count <= MAX_SHOWN) $display("%0t ns: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin : check_words
    btn_event_t want;
    int i;
    if (rst) begin
      btn_level = '0;
      btn_shown = '0;
      for (i = 0; i < BTN_N; i++) begin
        press_cnt[i]   = '0;
        release_cnt[i] = '0;
      end
      for (i = 0; i < NUM_REGS; i++) code_reg[i] = CODE_W'(i);
      pending_events.delete();
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        stall_cycles = 0;
        if (pending_events.size() == 0) begin
          log_error($sformatf("unexpected word change=%0d code=%0d pressed=%0d",
                              out_ch.change, out_ch.button_code, out_ch.pressed));
        end else begin
          want = pending_events.pop_front();
          if (out_ch.change !== want.change || out_ch.button_code !== want.code ||
              out_ch.pressed !== want.pressed)
            log_error($sformatf(
              "mismatch exp change=%0d code=%0d pressed=%0d got change=%0d code=%0d pressed=%0d",
              want.change, want.code, want.pressed,
              out_ch.change, out_ch.button_code, out_ch.pressed));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        stall_cycles = 0;
        if (in_ch.action == ACT_POLL) pending_events.push_back(take_next_event());
        else record_levels(in_ch.levels);
      end
      if (write_enable) begin
        stall_cycles = 0;
        if (write_index < NUM_REGS) code_reg[write_index] = write_data;
      end
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb_top: done, errors");
    $finish;
  end

  // receiver: random stall pattern, plus a long hold on request
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    bit hold_seen;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_word(input logic act, input logic [LEVEL_BITS-1:0] lv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) begin
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.levels <= lv;
    if (act == ACT_UPDATE) sent_levels = lv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_codes(input code_set_t codes, input bit touch_unused);
    int i;
    for (i = 0; i < NUM_REGS; i++) begin
      write_enable <= 1'b1;
      write_index  <= REG_ORDER[i];
      write_data   <= codes[i];
      @(posedge clk);
    end
    if (touch_unused) begin
      for (i = NUM_REGS; i < (1 << REG_IDX_W); i++) begin
        write_enable <= 1'b1;
        write_index  <= REG_IDX_W'(i);
        write_data   <= CODE_W'($urandom);
        @(posedge clk);
      end
    end
    write_enable <= 1'b0;
  endtask

  function automatic logic [CODE_W-1:0] pick_code();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return CODE_W'($urandom);
    endcase
  endfunction

  function automatic logic [LEVEL_BITS-1:0] flip_one(input logic [LEVEL_BITS-1:0] lv);
    return lv ^ (LEVEL_BITS'(1) << $urandom_range(0, LEVEL_BITS - 1));
  endfunction

  // empty poll, single press/release, queued pairs, all buttons at once
  task automatic test_directed();
    int i;
    send_word(ACT_POLL, '0);
    send_word(ACT_UPDATE, 5'h01);
    send_word(ACT_POLL, '0);
    send_word(ACT_UPDATE, 5'h00);
    send_word(ACT_POLL, '1);
    send_word(ACT_POLL, '0);
    send_word(ACT_UPDATE, '1);
    send_word(ACT_UPDATE, '0);
    send_word(ACT_UPDATE, '1);
    for (i = 0; i < 8; i++) send_word(ACT_POLL, '0);
    send_word(ACT_UPDATE, '0);
    send_word(ACT_UPDATE, 5'h15);
    send_word(ACT_UPDATE, 5'h0A);
    for (i = 0; i < 5; i++) send_word(ACT_POLL, '1);
  endtask

  // code registers at all-ones, all-zeros and random, unused indexes ignored
  task automatic test_codes();
    code_set_t codes;
    int s;
    int i;
    for (s = 0; s < 3; s++) begin
      settle();
      for (i = 0; i < NUM_REGS; i++)
        codes[i] = (s == 0) ? '1 : (s == 1) ? '0 : pick_code();
      load_codes(codes, 1'b1);
      send_word(ACT_UPDATE, '1);
      for (i = 0; i < 5; i++) send_word(ACT_POLL, '0);
      send_word(ACT_UPDATE, '0);
      for (i = 0; i < 6; i++) send_word(ACT_POLL, '0);
    end
  endtask

  // drive one button's counters past full, then drain them
  task automatic test_saturation();
    int k;
    int n;
    logic [LEVEL_BITS-1:0] lv;
    k  = $urandom_range(0, BTN_N - 1);
    lv = sent_levels;
    for (n = 0; n < 2 * (1 << CNT_W) + 8; n++) begin
      lv[k] = ~lv[k];
      send_word(ACT_UPDATE, lv);
    end
    for (n = 0; n < 2 * (1 << CNT_W) + 20; n++) send_word(ACT_POLL, LEVEL_BITS'($urandom));
  endtask

  task automatic test_random();
    code_set_t codes;
    int phase;
    int n;
    int r;
    int i;
    for (phase = 0; phase < 4; phase++) begin
      settle();
      for (i = 0; i < NUM_REGS; i++) codes[i] = pick_code();
      load_codes(codes, phase == 0);
      gap_max = (phase == 1) ? 0 : (phase == 2) ? 12 : 4;
      for (n = 0; n < 200; n++) begin
        r = $urandom_range(0, 99);
        if (r < 45)      send_word(ACT_POLL, LEVEL_BITS'($urandom));
        else if (r < 85) send_word(ACT_UPDATE, flip_one(sent_levels));
        else if (r < 93) send_word(ACT_UPDATE, LEVEL_BITS'($urandom));
        else             send_word(ACT_UPDATE, sent_levels);
      end
    end
  endtask

  // receiver holds off while words keep coming back to back
  task automatic test_backpressure();
    int n;
    settle();
    gap_max    = 0;
    burst_left = 0;
    hold_len  <= LONG_HOLD;
    hold_go   <= ~hold_go;
    for (n = 0; n < 60; n++) begin
      if (n % 2 == 0) send_word(ACT_UPDATE, flip_one(sent_levels));
      else            send_word(ACT_POLL, LEVEL_BITS'($urandom));
    end
    gap_max = 4;
  endtask

  initial begin
    err_count     = 0;
    stall_cycles  = 0;
    gap_max       = 3;
    burst_left    = 0;
    sent_levels   = '0;
    rst          <= 1'b1;
    write_enable <= 1'b0;
    write_index  <= '0;
    write_data   <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.action <= ACT_UPDATE;
    in_ch.levels <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_codes();
    test_saturation();
    test_random();
    test_backpressure();
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/btnq_pkg.sv
rtl/btnq_if.sv
rtl/btnq_cfg.sv
rtl/btnq_state.sv
rtl/button_transition_event_queue_core.sv
tb/sv/tb_top.sv
